// ----- hdl/dli_pkg.sv -----
// Package for the distance look-up interpolator.
// Holds the widths, register indexes, reset table and pipeline payload types.
// No dependencies; used by distance_lut_interpolator, dli_checker and the testbench.
package dli_pkg;

	// Widths of the sample, the distance and the calibration points.
	localparam int SAMPLE_BITS = 10;
	localparam int DIST_BITS = 8;
	localparam int POINT_BITS = SAMPLE_BITS + DIST_BITS;
	localparam int NUM_POINTS = 7;
	localparam int PIDX_BITS = $clog2(NUM_POINTS);

	// Product of the raw offset and the distance step, and the quotient.
	localparam int PROD_BITS = SAMPLE_BITS + DIST_BITS;
	localparam int Q_BITS = DIST_BITS;
	localparam int QIDX_BITS = $clog2(Q_BITS);
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES = Q_BITS / BITS_PER_STAGE;

	// Configuration register map.
	localparam int CFG_INDEX_BITS = 4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_FIRST = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DISTANCE = CFG_INDEX_BITS'(NUM_POINTS);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [POINT_BITS-1:0] point_t;

	// Calibration points after reset: raw values fall as distance rises.
	localparam sample_t POINT_RAW_RESET [NUM_POINTS] = '{
		SAMPLE_BITS'(16'h01F4), SAMPLE_BITS'(16'h00FF), SAMPLE_BITS'(16'h00A7),
		SAMPLE_BITS'(16'h0072), SAMPLE_BITS'(16'h0057), SAMPLE_BITS'(16'h0044),
		SAMPLE_BITS'(16'h003A)
	};
	localparam dist_t POINT_DIST_RESET [NUM_POINTS] = '{
		8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd80
	};
	localparam dist_t MIN_DISTANCE_RESET = 8'd10;

	// Segment selected for one sample.
	typedef struct packed {
		logic in_range;
		sample_t numa;
		sample_t span;
		dist_t mag;
		logic neg;
		dist_t dh;
		dist_t limit;
	} seg_t;

	// Payload of the multiply and divide stages.
	typedef struct packed {
		logic in_range;
		logic [PROD_BITS-1:0] rem;
		sample_t span;
		logic neg;
		dist_t dh;
		dist_t limit;
		logic [Q_BITS-1:0] quot;
	} div_t;

endpackage

// ----- hdl/distance_lut_interpolator.sv -----
// Top level of the distance look-up interpolator.
// Depends on dli_pkg for widths, the register map and the stage payload types.
//
// Usage: raw_sample and distance_limit enter on the input channel
// (in_valid / in_stall); distance_cm, out_of_range and detected leave on the
// output channel (out_valid / out_stall). A beat moves when valid is high and
// stall is low. The configuration channel (cfg_valid / cfg_ready, cfg_index,
// cfg_data) writes point_0..point_6 at indexes 0..6 and min_distance at 7;
// other indexes are ignored. cfg_ready is always high.
// An accepted input beat reaches the output register through segment select,
// multiply, four divide stages of two quotient bits each, and the final add.
// One sample is taken every cycle unless in_stall is high.
// The pipeline advances as a whole; when the output holds a result that the
// receiver stalls, every stage holds and in_stall is raised, so nothing is
// lost or repeated. Reset clears all valid bits and loads the calibration
// registers with their default table.
module distance_lut_interpolator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dli_pkg::SAMPLE_BITS-1:0]     raw_sample,
	input  logic [dli_pkg::DIST_BITS-1:0]       distance_limit,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dli_pkg::DIST_BITS-1:0]       distance_cm,
	output logic                                out_of_range,
	output logic                                detected,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dli_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dli_pkg::POINT_BITS-1:0]      cfg_data
);

	dli_pkg::point_t point_q [dli_pkg::NUM_POINTS];
	dli_pkg::dist_t min_distance_q;

	logic advance;
	logic valid_s1;
	dli_pkg::seg_t seg_s1;
	dli_pkg::seg_t seg_next;
	// Element j is pipeline stage j+2: the product, then one per divide stage.
	logic valid_s [dli_pkg::DIV_STAGES+1];
	dli_pkg::div_t div_s [dli_pkg::DIV_STAGES+1];
	dli_pkg::dist_t final_sum;

	// Two restoring steps of the division by the segment span.
	function automatic dli_pkg::div_t div_stage(dli_pkg::div_t d, int unsigned stg);
		dli_pkg::div_t r;
		logic [dli_pkg::PROD_BITS-1:0] trial;
		int unsigned k;
		r = d;
		for (int b = 0; b < dli_pkg::BITS_PER_STAGE; b++) begin
			k = dli_pkg::Q_BITS - 1 - stg * dli_pkg::BITS_PER_STAGE - b;
			trial = dli_pkg::PROD_BITS'(r.span) << k;
			if (r.span != '0 && r.rem >= trial) begin
				r.rem = r.rem - trial;
				r.quot[dli_pkg::QIDX_BITS'(k)] = 1'b1;
			end
		end
		return r;
	endfunction

	// The whole pipeline moves unless a finished result is being held.
	assign advance = !out_valid || !out_stall;
	assign in_stall = !advance;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dli_pkg::NUM_POINTS; i++) begin
				point_q[i] <= {dli_pkg::POINT_RAW_RESET[i], dli_pkg::POINT_DIST_RESET[i]};
			end
			min_distance_q <= dli_pkg::MIN_DISTANCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index >= dli_pkg::REG_POINT_FIRST && cfg_index < dli_pkg::REG_MIN_DISTANCE) begin
				point_q[cfg_index[dli_pkg::PIDX_BITS-1:0]] <= cfg_data;
			end else if (cfg_index == dli_pkg::REG_MIN_DISTANCE) begin
				min_distance_q <= cfg_data[dli_pkg::DIST_BITS-1:0];
			end
		end
	end

	// Stage 1 logic: saturation check, then the first bracketing segment.
	always_comb begin
		dli_pkg::sample_t hi;
		dli_pkg::sample_t lo;
		dli_pkg::dist_t dl;
		logic [dli_pkg::DIST_BITS:0] diff;
		logic found;
		hi = '0;
		lo = '0;
		dl = '0;
		found = 1'b0;
		seg_next = '0;
		seg_next.limit = distance_limit;
		if (raw_sample >= point_q[0][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS]) begin
			seg_next.in_range = 1'b1;
			seg_next.dh = min_distance_q;
		end else if (raw_sample >
				point_q[dli_pkg::NUM_POINTS-1][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS]) begin
			for (int i = 0; i < dli_pkg::NUM_POINTS - 1; i++) begin
				if (!found &&
						raw_sample <= point_q[i][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS] &&
						raw_sample >= point_q[i+1][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS]) begin
					found = 1'b1;
					hi = point_q[i][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS];
					lo = point_q[i+1][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS];
					seg_next.dh = point_q[i][dli_pkg::DIST_BITS-1:0];
					dl = point_q[i+1][dli_pkg::DIST_BITS-1:0];
				end
			end
			seg_next.in_range = found;
			seg_next.numa = hi - raw_sample;
			seg_next.span = hi - lo;
		end
		// Distance step split into sign and magnitude.
		diff = {1'b0, dl} - {1'b0, seg_next.dh};
		if (seg_next.in_range && found) begin
			seg_next.neg = diff[dli_pkg::DIST_BITS];
			seg_next.mag = diff[dli_pkg::DIST_BITS] ?
				dli_pkg::DIST_BITS'(-diff) : diff[dli_pkg::DIST_BITS-1:0];
		end
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seg_s1 <= seg_next;
		end
	end

	// Stage 2: raw offset times the magnitude of the distance step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (advance) begin
			valid_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			div_s[0].in_range <= seg_s1.in_range;
			div_s[0].rem <= dli_pkg::PROD_BITS'(seg_s1.numa) * dli_pkg::PROD_BITS'(seg_s1.mag);
			div_s[0].span <= seg_s1.span;
			div_s[0].neg <= seg_s1.neg;
			div_s[0].dh <= seg_s1.dh;
			div_s[0].limit <= seg_s1.limit;
			div_s[0].quot <= '0;
		end
	end

	// Stages 3 to 6: two quotient bits each.
	for (genvar j = 1; j <= dli_pkg::DIV_STAGES; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (advance) begin
				valid_s[j] <= valid_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				div_s[j] <= div_stage(div_s[j-1], j - 1);
			end
		end
	end

	// Stage 7: apply the sign, add the upper distance, flag and compare.
	assign final_sum = div_s[dli_pkg::DIV_STAGES].neg ?
		div_s[dli_pkg::DIV_STAGES].dh - div_s[dli_pkg::DIV_STAGES].quot :
		div_s[dli_pkg::DIV_STAGES].dh + div_s[dli_pkg::DIV_STAGES].quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s[dli_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			distance_cm <= div_s[dli_pkg::DIV_STAGES].in_range ? final_sum : '0;
			out_of_range <= !div_s[dli_pkg::DIV_STAGES].in_range;
			detected <= div_s[dli_pkg::DIV_STAGES].in_range &&
				(final_sum <= div_s[dli_pkg::DIV_STAGES].limit);
		end
	end

endmodule

// ----- hdl/dli_checker.sv -----
// Port-level checks for the distance look-up interpolator.
// Depends on dli_pkg for port widths; bound to distance_lut_interpolator below.
module dli_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_stall,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [dli_pkg::DIST_BITS-1:0]       distance_cm,
	input  logic                                out_of_range,
	input  logic                                detected
);

	// An out-of-range result carries a zero distance and no detection.
	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> distance_cm == '0 && !detected)
		else $error("out-of-range result with nonzero distance or detection");

	// A held result backs up the whole pipeline to the input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input accepted while the output beat is held");

	// A free output never stalls the input.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the output is empty");

	// A stalled output beat keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance_cm) &&
			$stable(out_of_range) && $stable(detected))
		else $error("stalled output beat changed");

endmodule

bind distance_lut_interpolator dli_checker u_dli_checker (.*);

// ----- tb/distance_lut_interpolator_tb.sv -----
// Self-checking testbench for distance_lut_interpolator.
// Depends on dli_pkg for widths, types and register indexes; needs only the RTL.
// Every accepted sample is predicted here and compared with the result beat.
module distance_lut_interpolator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 11;
	localparam int PIPE_LATENCY = 7;
	localparam int IDLE_PERCENT = 24;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SAMPLE_MAX = (1 << dli_pkg::SAMPLE_BITS) - 1;
	localparam int DIST_MAX = (1 << dli_pkg::DIST_BITS) - 1;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int PAUSE_ITEMS = 20;
	localparam int QUIET_ITEMS = 200;

	typedef logic [dli_pkg::CFG_INDEX_BITS-1:0] cfg_index_t;
	localparam cfg_index_t REG_UNUSED_FIRST = cfg_index_t'(dli_pkg::REG_MIN_DISTANCE + 1);
	localparam cfg_index_t REG_INDEX_LAST = '1;

	// Calibration table and minimum distance after reset.
	localparam dli_pkg::point_t RESET_POINTS [dli_pkg::NUM_POINTS] = '{
		dli_pkg::point_t'(128010), dli_pkg::point_t'(65300), dli_pkg::point_t'(42782),
		dli_pkg::point_t'(29224), dli_pkg::point_t'(22322), dli_pkg::point_t'(17468),
		dli_pkg::point_t'(14928)
	};
	localparam dli_pkg::dist_t MIN_DIST_AT_RESET = dli_pkg::dist_t'(10);

	// One predicted result beat.
	typedef struct packed {
		dli_pkg::dist_t distance;
		logic out_of_range;
		logic detected;
	} range_result_t;

	// Clock and reset.
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Block ports.
	logic in_valid = 1'b0;
	logic in_stall;
	dli_pkg::sample_t raw_sample = '0;
	dli_pkg::dist_t distance_limit = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	dli_pkg::dist_t distance_cm;
	logic out_of_range;
	logic detected;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_index_t cfg_index = '0;
	dli_pkg::point_t cfg_data = '0;

	// Predictor state, kept in step with the register writes.
	dli_pkg::point_t cal_point [dli_pkg::NUM_POINTS];
	dli_pkg::dist_t cal_min_distance;

	range_result_t pending_results [$];
	int error_count = 0;
	int idle_cycles = 0;
	logic idle_enable = 1'b1;

	distance_lut_interpolator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.raw_sample     (raw_sample),
		.distance_limit (distance_limit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.distance_cm    (distance_cm),
		.out_of_range   (out_of_range),
		.detected       (detected),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	function automatic dli_pkg::point_t cal_entry(input int raw, input int cm);
		return {dli_pkg::sample_t'(raw), dli_pkg::dist_t'(cm)};
	endfunction

	// Expected distance, range flag and detection for one sample.
	function automatic range_result_t predict_range(input dli_pkg::sample_t raw,
			input dli_pkg::dist_t limit);
		range_result_t res;
		dli_pkg::sample_t hi;
		dli_pkg::sample_t lo;
		int dh;
		int dl;
		int span;
		int delta;
		logic found;
		dli_pkg::dist_t dist_val;
		found = 1'b0;
		dist_val = '0;
		if (raw >= cal_point[0][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS]) begin
			dist_val = cal_min_distance;
			found = 1'b1;
		end else if (raw >
				cal_point[dli_pkg::NUM_POINTS-1][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS]) begin
			// The first segment that brackets the sample wins.
			for (int i = 0; i < dli_pkg::NUM_POINTS - 1; i++) begin
				hi = cal_point[i][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS];
				lo = cal_point[i+1][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS];
				if (!found && raw <= hi && raw >= lo) begin
					dh = int'(cal_point[i][dli_pkg::DIST_BITS-1:0]);
					dl = int'(cal_point[i+1][dli_pkg::DIST_BITS-1:0]);
					span = int'(hi) - int'(lo);
					delta = 0;
					if (span != 0)
						delta = ((int'(hi) - int'(raw)) * (dl - dh)) / span;
					dist_val = dli_pkg::dist_t'(dh + delta);
					found = 1'b1;
				end
			end
		end
		res.distance = found ? dist_val : '0;
		res.out_of_range = !found;
		res.detected = found && (dist_val <= limit);
		return res;
	endfunction

	// Send one sample beat; valid stays high on return so back-to-back beats need no gap.
	task automatic send_sample(input dli_pkg::sample_t raw, input dli_pkg::dist_t limit);
		while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_sample <= raw;
		distance_limit <= limit;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_range(raw, limit));
	endtask

	// Stop sending and wait until every expected result beat has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One configuration beat; the predictor is updated at the accepting edge.
	task automatic write_register(input cfg_index_t index, input dli_pkg::point_t data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (index < dli_pkg::REG_MIN_DISTANCE)
			cal_point[index[dli_pkg::PIDX_BITS-1:0]] = data;
		else if (index == dli_pkg::REG_MIN_DISTANCE)
			cal_min_distance = data[dli_pkg::DIST_BITS-1:0];
	endtask

	// Load a whole table while the pipeline is empty, then poke an unused index.
	task automatic load_table(input dli_pkg::point_t pts [dli_pkg::NUM_POINTS],
			input dli_pkg::point_t min_word);
		drain_results();
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		for (int i = 0; i < dli_pkg::NUM_POINTS; i++)
			write_register(cfg_index_t'(dli_pkg::REG_POINT_FIRST + i), pts[i]);
		write_register(dli_pkg::REG_MIN_DISTANCE, min_word);
		write_register(cfg_index_t'($urandom_range(REG_INDEX_LAST, REG_UNUSED_FIRST)),
			dli_pkg::point_t'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random table: mostly falling raw values, sometimes flat runs, unordered or the default.
	task automatic load_random_table();
		dli_pkg::point_t pts [dli_pkg::NUM_POINTS];
		int mode;
		int level;
		mode = $urandom_range(9);
		level = $urandom_range(SAMPLE_MAX, 300);
		for (int i = 0; i < dli_pkg::NUM_POINTS; i++) begin
			if (mode == 0) begin
				pts[i] = cal_entry($urandom_range(SAMPLE_MAX), $urandom_range(DIST_MAX));
			end else if (mode == 1) begin
				pts[i] = RESET_POINTS[i];
			end else begin
				pts[i] = cal_entry(level, $urandom_range(DIST_MAX));
				if (mode == 2)
					level = level - int'($urandom_range(3));
				else
					level = level - int'($urandom_range(160));
				if (level < 0)
					level = 0;
			end
		end
		load_table(pts, dli_pkg::point_t'($urandom));
	endtask

	// Random sample aimed mostly inside the current segments, with the limit near the answer half the time.
	task automatic send_random_sample();
		range_result_t guess;
		int pick;
		int seg;
		int a;
		int b;
		int r;
		int lim;
		pick = $urandom_range(99);
		if (pick < 60) begin
			seg = $urandom_range(dli_pkg::NUM_POINTS - 2);
			a = int'(cal_point[seg][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS]);
			b = int'(cal_point[seg+1][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS]);
			r = (a > b) ? int'($urandom_range(a, b)) : int'($urandom_range(b, a));
		end else if (pick < 75) begin
			seg = $urandom_range(dli_pkg::NUM_POINTS - 1);
			r = int'(cal_point[seg][dli_pkg::POINT_BITS-1:dli_pkg::DIST_BITS]) +
				int'($urandom_range(2)) - 1;
			if (r < 0)
				r = 0;
			if (r > SAMPLE_MAX)
				r = SAMPLE_MAX;
		end else begin
			r = $urandom_range(SAMPLE_MAX);
		end
		if ($urandom_range(1) == 0) begin
			lim = $urandom_range(DIST_MAX);
		end else begin
			guess = predict_range(dli_pkg::sample_t'(r), '0);
			lim = int'(guess.distance) + int'($urandom_range(2)) - 1;
			if (lim < 0)
				lim = 0;
			if (lim > DIST_MAX)
				lim = DIST_MAX;
		end
		send_sample(dli_pkg::sample_t'(r), dli_pkg::dist_t'(lim));
	endtask

	// Reset table: saturation, exact points, segment edges and the low end.
	task automatic test_default_table();
		send_sample(dli_pkg::sample_t'(SAMPLE_MAX), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(500), dli_pkg::dist_t'(9));
		send_sample(dli_pkg::sample_t'(499), dli_pkg::dist_t'(10));
		send_sample(dli_pkg::sample_t'(255), dli_pkg::dist_t'(20));
		send_sample(dli_pkg::sample_t'(192), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(59), dli_pkg::dist_t'(80));
		send_sample(dli_pkg::sample_t'(58), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(0), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(512), dli_pkg::dist_t'(0));
	endtask

	// Full-scale swings, an unordered table, flat tables and extreme minimum distances.
	task automatic test_register_extremes();
		dli_pkg::point_t pts [dli_pkg::NUM_POINTS];
		// Alternating full-range distance steps over the whole raw span.
		pts = '{cal_entry(SAMPLE_MAX, 0), cal_entry(512, DIST_MAX), cal_entry(256, 0),
			cal_entry(128, DIST_MAX), cal_entry(64, 0), cal_entry(1, DIST_MAX),
			cal_entry(0, 0)};
		load_table(pts, '1);
		send_sample(dli_pkg::sample_t'(SAMPLE_MAX), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(SAMPLE_MAX), dli_pkg::dist_t'(DIST_MAX - 1));
		send_sample(dli_pkg::sample_t'(700), dli_pkg::dist_t'(0));
		send_sample(dli_pkg::sample_t'(512), dli_pkg::dist_t'(DIST_MAX - 1));
		send_sample(dli_pkg::sample_t'(511), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(1), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(0), dli_pkg::dist_t'(DIST_MAX));
		// Unordered table: saturation is checked first, and falling distances truncate toward zero.
		pts = '{cal_entry(300, 5), cal_entry(600, 100), cal_entry(900, 200),
			cal_entry(100, 50), cal_entry(200, 7), cal_entry(50, 9), cal_entry(20, 3)};
		load_table(pts, cal_entry(SAMPLE_MAX, 0));
		send_sample(dli_pkg::sample_t'(300), dli_pkg::dist_t'(0));
		send_sample(dli_pkg::sample_t'(SAMPLE_MAX), dli_pkg::dist_t'(0));
		send_sample(dli_pkg::sample_t'(150), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(21), dli_pkg::dist_t'(3));
		// Every point at full scale: all raw values equal.
		pts = '{default: '1};
		load_table(pts, cal_entry(0, 128));
		send_sample(dli_pkg::sample_t'(SAMPLE_MAX - 1), dli_pkg::dist_t'(DIST_MAX));
		send_sample(dli_pkg::sample_t'(SAMPLE_MAX), dli_pkg::dist_t'(128));
		// Every point at zero: every sample saturates.
		pts = '{default: '0};
		load_table(pts, cal_entry(0, 77));
		send_sample(dli_pkg::sample_t'(0), dli_pkg::dist_t'(76));
		send_sample(dli_pkg::sample_t'(682), dli_pkg::dist_t'(DIST_MAX));
	endtask

	// Several random tables, each followed by a stream of random samples.
	task automatic test_random_tables();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_random_table();
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_sample();
		end
	endtask

	// The sender stops mid-stream until the pipeline has emptied, then carries on.
	task automatic test_sender_pause();
		for (int n = 0; n < PAUSE_ITEMS; n++)
			send_random_sample();
		drain_results();
		for (int n = 0; n < PAUSE_ITEMS; n++)
			send_random_sample();
	endtask

	// A long run with no idling on either side, so the pipeline runs full.
	task automatic test_quiet_stretch();
		idle_enable <= 1'b0;
		load_random_table();
		for (int n = 0; n < QUIET_ITEMS; n++)
			send_random_sample();
		idle_enable <= 1'b1;
	endtask

	// Receiver: random stalls, and each accepted result beat is checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		range_result_t want;
		out_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with no sample waiting (distance_cm %0d)",
					$time, distance_cm);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (distance_cm !== want.distance) begin
					$display("%0t: distance_cm expected %0d actual %0d",
						$time, want.distance, distance_cm);
					error_count++;
				end
				if (out_of_range !== want.out_of_range) begin
					$display("%0t: out_of_range expected %0b actual %0b",
						$time, want.out_of_range, out_of_range);
					error_count++;
				end
				if (detected !== want.detected) begin
					$display("%0t: detected expected %0b actual %0b",
						$time, want.detected, detected);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too many cycles without any beat on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("distance_lut_interpolator_tb: errors");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		for (int i = 0; i < dli_pkg::NUM_POINTS; i++)
			cal_point[i] = RESET_POINTS[i];
		cal_min_distance = MIN_DIST_AT_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_table();
		test_register_extremes();
		test_random_tables();
		test_sender_pause();
		test_quiet_stretch();
		drain_results();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("distance_lut_interpolator_tb: clean");
		end else begin
			$display("distance_lut_interpolator_tb: errors");
		end
		$finish;
	end

endmodule
